// ===== hdl/obd_pkg.sv =====
`default_nettype none

package obd_pkg;

    localparam int unsigned LFSR_W = 13;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 13'h0201;

    // rs block of 96 bytes: 94 data then 2 parity
    localparam int unsigned RS_W = 7;
    localparam logic [RS_W-1:0] RS_LAST_DATA = 7'd93;
    localparam logic [RS_W-1:0] RS_FIRST_PARITY = 7'd94;
    localparam logic [RS_W-1:0] RS_LAST = 7'd95;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_start;
    } obd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_parity;
        logic       last_of_packet;
    } obd_out_t;

    // per-byte position flags handed from the frame tracker to the core
    typedef struct packed {
        logic is_parity;
        logic last_of_packet;
    } obd_pos_info_t;

    // one lfsr step: taps at stages 1, 10, 11 and 13
    function automatic logic lfsr_feedback(input logic [LFSR_W-1:0] s);
        return s[0] ^ s[9] ^ s[10] ^ s[12];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/obd_frame_tracker.sv =====
`default_nettype none

module obd_frame_tracker
    import obd_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 384
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic          frame_start,
    output logic [7:0]         pn_byte,
    output obd_pos_info_t      pos_info
);

    localparam int unsigned POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_END = POS_W'(FRAME_BYTES - 1);

    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [RS_W-1:0]   rs_reg, rs_next;
    logic              half_reg, half_next;

    logic [LFSR_W-1:0] lfsr_cur;
    logic [LFSR_W-1:0] lfsr_step;
    logic [POS_W-1:0]  pos_cur;
    logic [RS_W-1:0]   rs_cur;
    logic              half_cur;
    logic              fb;

    // a start flag restarts the frame on this very byte
    always_comb
    begin
        lfsr_cur = frame_start ? LFSR_SEED : lfsr_reg;
        pos_cur  = frame_start ? '0 : pos_reg;
        rs_cur   = frame_start ? '0 : rs_reg;
        half_cur = frame_start ? 1'b0 : half_reg;
    end

    // eight steps per byte, first bit into the msb
    always_comb
    begin
        lfsr_step = lfsr_cur;
        pn_byte   = '0;
        for (int k = 0; k < 8; k++)
        begin
            fb        = lfsr_feedback(lfsr_step);
            lfsr_step = {fb, lfsr_step[LFSR_W-1:1]};
            pn_byte   = {pn_byte[6:0], fb};
        end
    end

    always_comb
    begin
        pos_info.is_parity      = (rs_cur >= RS_FIRST_PARITY);
        pos_info.last_of_packet = half_cur && (rs_cur == RS_LAST_DATA);
    end

    always_comb
    begin
        lfsr_next = lfsr_reg;
        pos_next  = pos_reg;
        rs_next   = rs_reg;
        half_next = half_reg;
        if (advance)
        begin
            if (pos_cur == POS_END)
            begin
                lfsr_next = LFSR_SEED;
                pos_next  = '0;
                rs_next   = '0;
                half_next = 1'b0;
            end
            else
            begin
                lfsr_next = lfsr_step;
                pos_next  = pos_cur + POS_W'(1);
                if (rs_cur == RS_LAST)
                begin
                    rs_next   = '0;
                    half_next = ~half_cur;
                end
                else
                begin
                    rs_next   = rs_cur + RS_W'(1);
                    half_next = half_cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= LFSR_SEED;
            pos_reg  <= '0;
            rs_reg   <= '0;
            half_reg <= 1'b0;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
            pos_reg  <= pos_next;
            rs_reg   <= rs_next;
            half_reg <= half_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/oob_byte_derandomizer_core.sv =====
`default_nettype none

// channel   | handshake                          | payload
// ----------+------------------------------------+-------------------------------
// item      | item_valid / item_stall            | item   (in_byte, frame_start)
// result    | result_valid / result_stall        | result (out_byte, is_parity,
//           |                                    |         last_of_packet)
// config    | drop_parity_we                     | drop_parity_wdata
//
// one byte per cycle while item_stall is low: a transaction is descrambled in the cycle it is taken
// and its result, unless dropped, appears from the output register on the next cycle
// rate set by the 8-step unrolled lfsr and the single output register
// reset: lfsr holds the seed, frame position zero, parity drop mode on
// item_stall rises only while the output register holds a stalled result
module oob_byte_derandomizer_core
    import obd_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 384
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    // input byte stream
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire obd_in_t  item,
    // result stream
    output logic          result_valid,
    input  wire logic     result_stall,
    output obd_out_t      result,
    // configuration
    input  wire logic     drop_parity_we,
    input  wire logic     drop_parity_wdata
);

    logic          drop_parity_reg;
    logic          result_valid_reg, result_valid_next;
    obd_out_t      result_reg, result_next;

    logic          accept;
    logic [7:0]    pn_byte;
    obd_pos_info_t pos_info;
    logic          drop_this;

    // output register is the only place to hold back
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    // lfsr and frame position, advanced once per accepted transaction
    obd_frame_tracker #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .frame_start (item.frame_start),
        .pn_byte     (pn_byte),
        .pos_info    (pos_info)
    );

    // parity bytes pass unscrambled, or vanish in drop mode
    assign drop_this = pos_info.is_parity && drop_parity_reg;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (!item_stall)
        begin
            result_valid_next          = accept && !drop_this;
            result_next.out_byte       = pos_info.is_parity ? item.in_byte
                                                            : (item.in_byte ^ pn_byte);
            result_next.is_parity      = pos_info.is_parity;
            result_next.last_of_packet = pos_info.last_of_packet;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_parity_reg  <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (drop_parity_we)
            begin
                drop_parity_reg <= drop_parity_wdata;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
